// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/elg_pkg.sv =====
package elg_pkg;

    localparam int TABLE_LEN = 31;
    localparam int HZ_W      = 15;
    localparam int PHON_W    = 7;
    localparam int IDX_W     = 5;

    localparam logic [HZ_W-1:0] CONTOUR_HZ [TABLE_LEN] = '{
        15'd20, 15'd25, 15'd31, 15'd40, 15'd50, 15'd63, 15'd80, 15'd100,
        15'd125, 15'd160, 15'd200, 15'd250, 15'd315, 15'd400, 15'd500,
        15'd630, 15'd800, 15'd1000, 15'd1250, 15'd1600, 15'd2000, 15'd2500,
        15'd3150, 15'd4000, 15'd5000, 15'd6300, 15'd8000, 15'd10000,
        15'd12500, 15'd16000, 15'd20000};

    localparam logic [PHON_W-1:0] CONTOUR_PHON [TABLE_LEN] = '{
        7'd109, 7'd104, 7'd99, 7'd94, 7'd89, 7'd85, 7'd82, 7'd78, 7'd75,
        7'd72, 7'd69, 7'd67, 7'd65, 7'd63, 7'd62, 7'd60, 7'd59, 7'd60,
        7'd62, 7'd63, 7'd59, 7'd57, 7'd56, 7'd57, 7'd60, 7'd66, 7'd71,
        7'd73, 7'd68, 7'd68, 7'd104};

    localparam logic signed [7:0] REF_PHON = 8'sd60;

    typedef enum logic [1:0] {
        REGION_INTERP = 2'd0,
        REGION_BELOW  = 2'd1,
        REGION_ABOVE  = 2'd2
    } t_region;

    // log2(10) and ln(2) in Q32
    localparam logic [33:0] LOG2_10_Q32 = 34'h35269E12F;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;

    // quotient bits of the exponent: |e| < 16 in Q32
    localparam int QW        = 36;
    localparam int EXP_TERMS = 13;
    // integer part of e is biased by 16; k + 9 = biased - 7
    localparam logic [4:0] K_SHIFT_OFF = 5'd7;
    localparam int K_SHIFT_MAX = 17;

    // floor(x / n) = (x * RECIP_M[n]) >> RECIP_SH[n] for 32-bit x
    localparam logic [32:0] RECIP_M [2:EXP_TERMS] = '{
        33'd4294967296, 33'd5726623062, 33'd4294967296, 33'd6871947674,
        33'd5726623062, 33'd4908534053, 33'd4294967296, 33'd7635497416,
        33'd6871947674, 33'd6247225158, 33'd5726623062, 33'd5286113596};

    localparam int RECIP_SH [2:EXP_TERMS] = '{
        33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36, 36};

endpackage

// ===== rtl/core/elg_fifo.sv =====
`include "assert_macros.svh"

module elg_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    logic [W-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0] r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    `ASSERT_AT(a_count_bound, i_clk, i_rst_n, r_count <= (PTR_W+1)'(DEPTH), "fifo overfull")
    `ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && !i_push, r_count == $past(r_count) - 1'b1, "pop lost")

endmodule

// ===== rtl/core/elg_front.sv =====
module elg_front #(
    parameter int FREQ_FRAC_BITS = 4,
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [19:0]  i_freq_in,
    output logic         o_push,
    output logic [W-1:0] o_item,
    input  logic         i_full
);
    import elg_pkg::*;

    localparam int DW   = HZ_W + FREQ_FRAC_BITS;
    localparam int MAGW = DW + 7;
    localparam int NW   = MAGW + 1;
    localparam int CW   = 20 + FREQ_FRAC_BITS;

    logic [TABLE_LEN-1:0] lt;
    logic                 r_f_valid;
    logic [19:0]          r_f_freq;
    logic [IDX_W-1:0]     r_f_idx;

    logic [IDX_W-1:0]     ip, inx;
    logic [CW-1:0]        fp, fn;
    logic [DW-1:0]        a, b;
    logic [PHON_W-1:0]    pp;
    logic signed [7:0]    t1, dp;
    logic signed [NW-1:0] num;
    logic [MAGW-1:0]      mag;
    t_region              region;

    always_comb begin
        for (int i = 0; i < TABLE_LEN; i++) begin
            lt[i] = ((CW'(CONTOUR_HZ[i]) << FREQ_FRAC_BITS) < CW'(i_freq_in));
        end
    end

    assign o_push  = r_f_valid && !i_full;
    assign o_ready = !r_f_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (o_ready) begin
            r_f_valid <= i_valid;
        end
    end

    // table is ascending, so the count of points below the input is the index
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_f_freq <= i_freq_in;
            r_f_idx  <= IDX_W'($countones(lt));
        end
    end

    always_comb begin
        ip  = (r_f_idx == '0) ? '0 : r_f_idx - 1'b1;
        inx = (r_f_idx == IDX_W'(TABLE_LEN)) ? IDX_W'(TABLE_LEN - 1) : r_f_idx;
        fp  = CW'(CONTOUR_HZ[ip]) << FREQ_FRAC_BITS;
        fn  = CW'(CONTOUR_HZ[inx]) << FREQ_FRAC_BITS;
        if (r_f_idx == '0) begin
            region = REGION_BELOW;
            pp     = CONTOUR_PHON[0];
            dp     = '0;
            a      = '0;
            b      = DW'(1);
        end else if (r_f_idx == IDX_W'(TABLE_LEN)) begin
            region = REGION_ABOVE;
            pp     = CONTOUR_PHON[TABLE_LEN-1];
            dp     = '0;
            a      = '0;
            b      = DW'(1);
        end else begin
            region = REGION_INTERP;
            pp     = CONTOUR_PHON[ip];
            dp     = $signed({1'b0, CONTOUR_PHON[inx]}) - $signed({1'b0, pp});
            a      = DW'(CW'(r_f_freq) - fp);
            b      = DW'(fn - fp);
        end
        t1  = REF_PHON - $signed({1'b0, pp});
        num = NW'(t1) * NW'($signed({1'b0, b})) - NW'(dp) * NW'($signed({1'b0, a}));
        mag = num[NW-1] ? MAGW'(-num) : MAGW'(num);
    end

    assign o_item = {num[NW-1], mag, b, region};

endmodule

// ===== rtl/core/elg_back.sv =====
`include "assert_macros.svh"

module elg_back #(
    parameter int FREQ_FRAC_BITS = 4,
    parameter int GAIN_FRAC_BITS = 20,
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_item,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [20:0]  o_gain_out,
    output logic [1:0]   o_region
);
    import elg_pkg::*;

    localparam int DW   = HZ_W + FREQ_FRAC_BITS;
    localparam int MAGW = DW + 7;
    localparam int DVW  = DW + 5;
    localparam int PW   = MAGW + 34;
    localparam int LOW  = MAGW + 17;
    localparam int SW   = 34;
    localparam int VW   = SW + K_SHIFT_MAX;
    localparam int SHP  = 41 - GAIN_FRAC_BITS;

    logic en;

    logic            s_sgn;
    logic [MAGW-1:0] s_mag;
    logic [DW-1:0]   s_den;
    logic [1:0]      s_reg;

    logic            r1_v, r1_sgn;
    logic [LOW-1:0]  r1_lo;
    logic [MAGW-1:0] r1_mag;
    logic [DW-1:0]   r1_den;
    logic [1:0]      r1_reg;

    logic            d_v   [0:QW];
    logic            d_sgn [0:QW];
    logic [1:0]      d_reg [0:QW];
    logic [PW-1:0]   d_rem [0:QW];
    logic [DVW-1:0]  d_div [0:QW];
    logic [QW-1:0]   d_q   [0:QW];

    logic            r_u_v;
    logic [1:0]      r_u_reg;
    logic [QW:0]     r_u;
    logic [QW:0]     qmag;
    logic [QW:0]     bias;

    logic [63:0]     zp;

    logic            t_v    [1:EXP_TERMS];
    logic [1:0]      t_reg  [1:EXP_TERMS];
    logic [4:0]      t_kj   [1:EXP_TERMS];
    logic [31:0]     t_z    [1:EXP_TERMS];
    logic [31:0]     t_term [1:EXP_TERMS];
    logic [SW-1:0]   t_sum  [1:EXP_TERMS];

    logic            x_v    [2:EXP_TERMS];
    logic [1:0]      x_reg  [2:EXP_TERMS];
    logic [4:0]      x_kj   [2:EXP_TERMS];
    logic [31:0]     x_z    [2:EXP_TERMS];
    logic [31:0]     x_val  [2:EXP_TERMS];
    logic [SW-1:0]   x_sum  [2:EXP_TERMS];

    logic [VW-1:0]   val, rnd, res, lim;

    logic            r_o_valid;
    logic [20:0]     r_o_gain;
    logic [1:0]      r_o_reg;

    assign {s_sgn, s_mag, s_den, s_reg} = i_item;

    // whole pipe advances together; it holds only while the output beat waits
    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && i_valid;

    // magnitude times log2(10), in two halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_lo  <= LOW'(s_mag) * LOW'(LOG2_10_Q32[16:0]);
            r1_mag <= s_mag;
            r1_den <= s_den;
            r1_sgn <= s_sgn;
            r1_reg <= s_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) d_v[0] <= 1'b0;
        else if (en)  d_v[0] <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            d_rem[0] <= PW'(r1_lo) + (PW'(LOW'(r1_mag) * LOW'(LOG2_10_Q32[33:17])) << 17);
            d_div[0] <= (DVW'(r1_den) << 4) + (DVW'(r1_den) << 2);
            d_q[0]   <= '0;
            d_sgn[0] <= r1_sgn;
            d_reg[0] <= r1_reg;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        logic [PW-1:0] shd;
        logic          ge;
        assign shd = PW'(d_div[j]) << B;
        assign ge  = (d_rem[j] >= shd);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) d_v[j+1] <= 1'b0;
            else if (en)  d_v[j+1] <= d_v[j];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                d_rem[j+1] <= ge ? d_rem[j] - shd : d_rem[j];
                d_q[j+1]   <= d_q[j] | (QW'(ge) << B);
                d_div[j+1] <= d_div[j];
                d_sgn[j+1] <= d_sgn[j];
                d_reg[j+1] <= d_reg[j];
            end
        end
    end

    // negative exponent rounds toward minus infinity; bias by 16 to split k and f
    assign qmag = (QW+1)'(d_q[QW]) + (QW+1)'(d_sgn[QW] && (d_rem[QW] != '0));
    assign bias = (QW+1)'(16) << 32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_u_v <= 1'b0;
        else if (en)  r_u_v <= d_v[QW];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u     <= d_sgn[QW] ? bias - qmag : bias + qmag;
            r_u_reg <= d_reg[QW];
        end
    end

    assign zp = 64'(r_u[31:0]) * 64'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) t_v[1] <= 1'b0;
        else if (en)  t_v[1] <= r_u_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            t_z[1]    <= zp[63:32];
            t_term[1] <= zp[63:32];
            t_sum[1]  <= (SW'(1) << 32) + SW'(zp[63:32]);
            t_kj[1]   <= r_u[QW:32] - K_SHIFT_OFF;
            t_reg[1]  <= r_u_reg;
        end
    end

    // Taylor terms: multiply by z, then divide by n through a reciprocal
    for (genvar n = 2; n <= EXP_TERMS; n++) begin : g_exp
        logic [63:0] xp;
        logic [64:0] qp;
        logic [31:0] tn;
        assign xp = 64'(t_term[n-1]) * 64'(t_z[n-1]);
        assign qp = 65'(x_val[n]) * 65'(RECIP_M[n]);
        assign tn = 32'(qp >> RECIP_SH[n]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                x_v[n] <= 1'b0;
                t_v[n] <= 1'b0;
            end else if (en) begin
                x_v[n] <= t_v[n-1];
                t_v[n] <= x_v[n];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                x_val[n]  <= xp[63:32];
                x_sum[n]  <= t_sum[n-1];
                x_z[n]    <= t_z[n-1];
                x_kj[n]   <= t_kj[n-1];
                x_reg[n]  <= t_reg[n-1];
                t_term[n] <= tn;
                t_sum[n]  <= x_sum[n] + SW'(tn);
                t_z[n]    <= x_z[n];
                t_kj[n]   <= x_kj[n];
                t_reg[n]  <= x_reg[n];
            end
        end
    end

    // scale by 2^(k+9) then round away the fixed remaining shift
    always_comb begin
        val = VW'(t_sum[EXP_TERMS]) << t_kj[EXP_TERMS];
        rnd = val + (VW'(1) << (SHP - 1));
        res = rnd >> SHP;
        lim = (VW'(1) << (GAIN_FRAC_BITS + 1)) - VW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (en)  r_o_valid <= t_v[EXP_TERMS];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_gain <= (res > lim) ? lim[20:0] : res[20:0];
            r_o_reg  <= t_reg[EXP_TERMS];
        end
    end

    assign o_valid    = r_o_valid;
    assign o_gain_out = r_o_gain;
    assign o_region   = r_o_reg;

    `ASSERT_AT(a_div_rem, i_clk, i_rst_n, d_v[QW] |-> (d_rem[QW] < PW'(d_div[QW])), "divider remainder not reduced")
    `ASSERT_AT(a_exp_range, i_clk, i_rst_n, t_v[EXP_TERMS] |-> !t_sum[EXP_TERMS][SW-1], "2^f sum out of range")

endmodule

// ===== rtl/core/equal_loudness_gain.sv =====
// channel | dir | beat                        | handshake
// --------+-----+-----------------------------+------------------
// in      | in  | i_freq_in (Q.4 Hz)          | i_valid / o_ready
// out     | out | o_gain_out (Q1.20), o_region | o_valid / i_ready
//
// One beat per cycle sustained while the output is not stalled; after the front
// register and queue slot, a beat passes two product registers, 36 divider stages,
// two exponent registers, 24 Taylor stages and an output register.
// Latency is set by the pipelined exponent divider (one quotient bit per stage)
// and the 13-term exp series.
// Reset is synchronous and clears only valid flags and the queue's pointers and count.
// A stalled output freezes the back pipe; the 4-deep queue takes front beats until full.
module equal_loudness_gain #(
    parameter int FREQ_FRAC_BITS = 4,
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_freq_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_gain_out,
    output logic [1:0]  o_region
);
    import elg_pkg::*;

    localparam int DW   = HZ_W + FREQ_FRAC_BITS;
    localparam int MAGW = DW + 7;
    localparam int W    = 3 + MAGW + DW;

    logic         push, full, q_valid, pop;
    logic [W-1:0] push_item, q_item;

    elg_front #(
        .FREQ_FRAC_BITS(FREQ_FRAC_BITS),
        .W(W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_freq_in (i_freq_in),
        .o_push    (push),
        .o_item    (push_item),
        .i_full    (full)
    );

    elg_fifo #(
        .W(W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    elg_back #(
        .FREQ_FRAC_BITS(FREQ_FRAC_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .W(W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_gain_out (o_gain_out),
        .o_region   (o_region)
    );

endmodule
